/* rtl/core/exposure_gamma_tone_map_assert.svh */
// Assertion macros used by the checker file of the tone mapper.
// Depends on nothing; the including module provides clk_i and rst_ni.
`ifndef EXPOSURE_GAMMA_TONE_MAP_ASSERT_SVH
`define EXPOSURE_GAMMA_TONE_MAP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EGTM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define EGTM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/egtm_pkg.sv */
// Shared constants, types and the constant threshold table of the tone mapper.
// Depends on nothing.
package egtm_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int CH_W          = 24;
  localparam int OUT_W         = 8;
  localparam int EXP_W         = 12;
  localparam int GAM_W         = 15;
  localparam int GAMMA_RESET   = 9011;
  localparam int INV_W         = 29;
  localparam int INV_RESET     = (1 << 28) / GAMMA_RESET;
  localparam int MANT_W        = 31;
  localparam int POS_W         = 5;
  localparam int FRAC_W        = 16;
  localparam int L_W           = 23;
  localparam int Y_W           = 21;
  localparam int MAP_STAGES    = 5;
  localparam int PIPE_DEPTH    = 1 + FRAC_W + MAP_STAGES;
  localparam int ADDR_W        = 3;

  typedef enum logic {
    REG_EXPOSURE = 1'b0,
    REG_GAMMA    = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [MANT_W-1:0] mant;
    logic [FRAC_W-1:0] frac;
    logic              zero;
  } lg_t;

  typedef struct packed {
    logic             busy;
    logic [INV_W-1:0] inv;
  } recip_t;

  typedef logic signed [Y_W-1:0] thr_tab_t [256];

  function automatic int log2q_const(int v);
    int p;
    int frac;
    int t;
    longint unsigned m;
    p = 0;
    frac = 0;
    t = v;
    while (t > 1) begin
      t = t >> 1;
      p = p + 1;
    end
    m = longint'(v) << (30 - p);
    for (int i = 15; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac = frac | (1 << i);
      end
    end
    return p * 65536 + frac;
  endfunction

  function automatic thr_tab_t build_thr();
    thr_tab_t tab;
    int l255;
    l255 = log2q_const(255);
    tab[0] = '0;
    for (int c = 1; c < 256; c++) begin
      tab[c] = Y_W'(log2q_const(c) - l255);
    end
    return tab;
  endfunction

  localparam thr_tab_t THR = build_thr();

endpackage

/* rtl/core/egtm_recip.sv */
// Iterative reciprocal unit: forms floor(2^28 / gamma) one quotient bit per cycle.
// Depends on egtm_pkg.
module egtm_recip import egtm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [GAM_W-1:0] gamma_i,
  output recip_t           rc_o
);

  logic             busy_q;
  logic [POS_W-1:0] cnt_q;
  logic [GAM_W-1:0] rem_q, div_q;
  logic [INV_W-1:0] quo_q, inv_q;
  logic [GAM_W:0]   trial;
  logic             qbit;
  logic [GAM_W-1:0] rem_d;
  logic [INV_W-1:0] quo_d;

  always_comb begin
    trial = {rem_q, cnt_q == POS_W'(INV_W - 1)};
    qbit  = trial >= {1'b0, div_q};
    rem_d = qbit ? GAM_W'(trial - {1'b0, div_q}) : GAM_W'(trial);
    quo_d = {quo_q[INV_W-2:0], qbit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      inv_q  <= INV_W'(INV_RESET);
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= POS_W'(INV_W - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        inv_q  <= quo_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= (gamma_i == '0) ? GAM_W'(1) : gamma_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign rc_o = '{busy: busy_q, inv: inv_q};

endmodule

/* rtl/core/egtm_log2.sv */
// Pipelined fixed-point log2 of one channel: normalisation, then one squaring per stage.
// Depends on egtm_pkg.
module egtm_log2 import egtm_pkg::*; (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [CH_W-1:0] x_i,
  output lg_t             lg_o
);

  lg_t              st_q [FRAC_W+1];
  lg_t              st0_d;
  logic [POS_W-1:0] pos;

  always_comb begin
    pos = '0;
    for (int i = 0; i < CH_W; i++) begin
      if (x_i[i]) pos = POS_W'(i);
    end
    st0_d.pos  = pos;
    st0_d.mant = MANT_W'(x_i) << (POS_W'(MANT_W - 1) - pos);
    st0_d.frac = '0;
    st0_d.zero = (x_i == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) st_q[0] <= st0_d;
  end

  for (genvar k = 0; k < FRAC_W; k++) begin : g_sq
    logic [2*MANT_W-1:0] sq;
    lg_t                 nx;
    always_comb begin
      sq = (2*MANT_W)'(st_q[k].mant) * (2*MANT_W)'(st_q[k].mant);
      nx = st_q[k];
      if (sq[2*MANT_W-1]) begin
        nx.mant = sq[2*MANT_W-1:MANT_W];
        nx.frac[FRAC_W-1-k] = 1'b1;
      end else begin
        nx.mant = sq[2*MANT_W-2:MANT_W-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) st_q[k+1] <= nx;
    end
  end

  assign lg_o = st_q[FRAC_W];

endmodule

/* rtl/core/egtm_map.sv */
// Pipelined exposure, gamma scaling and output code search for one channel.
// Depends on egtm_pkg and its threshold table.
module egtm_map import egtm_pkg::*; (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  lg_t                     lg_i,
  input  logic signed [EXP_W-1:0] exp_i,
  input  logic [INV_W-1:0]        inv_i,
  output logic [OUT_W-1:0]        byte_o
);

  localparam int P_W = L_W + INV_W + 1;

  logic signed [L_W-1:0] pl, l_d, l_q;
  logic signed [P_W-1:0] prod_q;
  logic signed [P_W-FRAC_W-1:0] yw;
  logic signed [Y_W-1:0] y_d, y_q, y2_q;
  logic [OUT_W-1:0]      lo_d, lo_q, out_d, out_q, cand;
  logic                  z1_q, z2_q, z3_q, z4_q;

  always_comb begin
    pl  = L_W'($signed({1'b0, lg_i.pos})) - L_W'(FRACTION_BITS);
    l_d = (pl <<< FRAC_W) + L_W'($signed({1'b0, lg_i.frac})) + (L_W'(exp_i) <<< 8);
  end

  always_comb begin
    yw = P_W'(prod_q >>> FRAC_W) >= 0 ? (P_W-FRAC_W)'(prod_q >>> FRAC_W)
                                       : (P_W-FRAC_W)'(prod_q >>> FRAC_W);
    if (yw > (P_W-FRAC_W)'((1 << (Y_W - 1)) - 1)) begin
      y_d = Y_W'((1 << (Y_W - 1)) - 1);
    end else if (yw < -(P_W-FRAC_W)'(1 << (Y_W - 1))) begin
      y_d = Y_W'(-(1 << (Y_W - 1)));
    end else begin
      y_d = Y_W'(yw);
    end
  end

  always_comb begin
    lo_d = '0;
    for (int b = OUT_W - 1; b >= OUT_W / 2; b--) begin
      cand = lo_d | (OUT_W'(1) << b);
      if (THR[cand] <= y_q) lo_d = cand;
    end
    out_d = lo_q;
    for (int b = OUT_W / 2 - 1; b >= 0; b--) begin
      cand = out_d | (OUT_W'(1) << b);
      if (THR[cand] <= y2_q) out_d = cand;
    end
    if (z4_q) out_d = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      l_q    <= l_d;
      z1_q   <= lg_i.zero;
      prod_q <= P_W'(l_q) * P_W'($signed({1'b0, inv_i}));
      z2_q   <= z1_q;
      y_q    <= y_d;
      z3_q   <= z2_q;
      lo_q   <= lo_d;
      y2_q   <= y_q;
      z4_q   <= z3_q;
      out_q  <= out_d;
    end
  end

  assign byte_o = out_q;

endmodule

/* rtl/core/exposure_gamma_tone_map.sv */
// Exposure and gamma tone mapper: one HDR pixel per clock while not stalled, three bytes out,
// with latency set by the log2 squaring pipeline (one squaring per stage) and five mapping stages.
// Writing gamma starts an iterative reciprocal during which input beats are stalled.
// Depends on egtm_pkg, egtm_recip, egtm_log2 and egtm_map.
module exposure_gamma_tone_map import egtm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CH_W-1:0]   red_in_i,
  input  logic [CH_W-1:0]   green_in_i,
  input  logic [CH_W-1:0]   blue_in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [OUT_W-1:0]  red_out_o,
  output logic [OUT_W-1:0]  green_out_o,
  output logic [OUT_W-1:0]  blue_out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [EXP_W-1:0]      exp_q;
  logic [GAM_W-1:0]      gam_q;
  logic                  wr, gam_start, adv;
  logic [PIPE_DEPTH-1:0] vld_q;
  recip_t                rc;
  lg_t                   lg_r, lg_g, lg_b;

  assign pready    = 1'b1;
  assign wr        = psel && penable && pwrite;
  assign gam_start = wr && (reg_idx_e'(paddr[2]) == REG_GAMMA);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q <= '0;
      gam_q <= GAM_W'(GAMMA_RESET);
    end else if (wr) begin
      case (reg_idx_e'(paddr[2]))
        REG_EXPOSURE: exp_q <= pwdata[EXP_W-1:0];
        REG_GAMMA:    gam_q <= pwdata[GAM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[2]))
      REG_EXPOSURE: prdata = 32'(exp_q);
      REG_GAMMA:    prdata = 32'(gam_q);
      default:      prdata = '0;
    endcase
  end

  egtm_recip u_recip (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gam_start),
    .gamma_i (pwdata[GAM_W-1:0]),
    .rc_o    (rc)
  );

  assign adv         = !out_valid_o || !out_stall_i;
  assign in_stall_o  = !adv || rc.busy;
  assign out_valid_o = vld_q[PIPE_DEPTH-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[PIPE_DEPTH-2:0], in_valid_i && !rc.busy};
    end
  end

  egtm_log2 u_log_r (.clk_i(clk_i), .en_i(adv), .x_i(red_in_i),   .lg_o(lg_r));
  egtm_log2 u_log_g (.clk_i(clk_i), .en_i(adv), .x_i(green_in_i), .lg_o(lg_g));
  egtm_log2 u_log_b (.clk_i(clk_i), .en_i(adv), .x_i(blue_in_i),  .lg_o(lg_b));

  egtm_map u_map_r (
    .clk_i(clk_i), .en_i(adv), .lg_i(lg_r), .exp_i($signed(exp_q)), .inv_i(rc.inv),
    .byte_o(red_out_o)
  );
  egtm_map u_map_g (
    .clk_i(clk_i), .en_i(adv), .lg_i(lg_g), .exp_i($signed(exp_q)), .inv_i(rc.inv),
    .byte_o(green_out_o)
  );
  egtm_map u_map_b (
    .clk_i(clk_i), .en_i(adv), .lg_i(lg_b), .exp_i($signed(exp_q)), .inv_i(rc.inv),
    .byte_o(blue_out_o)
  );

endmodule

/* rtl/core/egtm_checker.sv */
// Port-level checker for the tone mapper and its bind to the top level.
// Depends on egtm_pkg and the shared assertion macro header.
`include "exposure_gamma_tone_map_assert.svh"

module egtm_checker import egtm_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic [CH_W-1:0]   red_in_i,
  input logic [CH_W-1:0]   green_in_i,
  input logic [CH_W-1:0]   blue_in_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [OUT_W-1:0]  red_out_o,
  input logic [OUT_W-1:0]  green_out_o,
  input logic [OUT_W-1:0]  blue_out_o,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [ADDR_W-1:0] paddr,
  input logic [31:0]       pwdata,
  input logic [31:0]       prdata,
  input logic              pready
);

  logic gam_wr, exp_wr;

  assign gam_wr = psel && penable && pwrite && paddr[2];
  assign exp_wr = psel && penable && pwrite && !paddr[2];

  `EGTM_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(red_out_o) && $stable(green_out_o) && $stable(blue_out_o), "output beat changed while stalled")
  `EGTM_ASSERT_SAME(a_ready, psel && penable, pready, "access phase without pready")
  `EGTM_ASSERT_NEXT(a_gam_stall, gam_wr, in_stall_o, "input not stalled during reciprocal")
  `EGTM_ASSERT_NEXT(a_exp_read, exp_wr, paddr[2] || prdata[EXP_W-1:0] == $past(pwdata[EXP_W-1:0]), "exposure readback mismatch")

endmodule

bind exposure_gamma_tone_map egtm_checker u_chk (.*);
